// File: hw/rtl/ckt_pkg.sv
// ============================================================================
// ckt_pkg - shared types and constants of the compacting keyed table
// Field widths, the layout of one stored entry and the operation and status
// codes carried on the stream sidebands.
// ============================================================================
package ckt_pkg;

    localparam int NAME_W   = 256;
    localparam int TAG_W    = 192;
    localparam int AMOUNT_W = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    // One entry as stored: name in the low bits, then tag, then quantity.
    localparam int NAME_LO   = 0;
    localparam int TAG_LO    = NAME_LO + NAME_W;
    localparam int AMOUNT_LO = TAG_LO + TAG_W;
    localparam int ENTRY_W   = AMOUNT_LO + AMOUNT_W;

    // Slave tdata carries exactly one entry; master tdata is padded to bytes.
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_DATA_W  = POS_W + ENTRY_W;
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_LIST   = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LIST_EMPTY = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_LIST  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

endpackage

// File: hw/rtl/ckt_ram.sv
// ============================================================================
// ckt_ram - generic simple dual-port RAM
// One write port and one read port; the read data is registered and only
// updates when a read is enabled, so it holds while the reader stalls.
// ============================================================================
module ckt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/compacting_keyed_table.sv
// ============================================================================
// compacting_keyed_table - bounded ordered table with search by name
// Entries are appended at the end; a remove closes the gap by moving later
// entries down. Search and remove walk the table from the front.
// ============================================================================
//
//  channel | direction | tdata (low bit up)                  | tuser  | tlast
//  --------+-----------+-------------------------------------+--------+------
//  s_axis  | in        | name_w0..3, tag_w0..2, amount       | mode   | -
//  m_axis  | out       | position, out_name_w0..3,           | status | last
//          |           | out_tag_w0..2, out_amount, 0 pad    |        |
//
//  All entries live in one RAM with a registered read port; every walk reads
//  one entry per cycle, and a list walk only while the output register is
//  free. A new beat is taken once the previous operation has handed its last
//  result to the output register. Reset empties the table at once.
//
module compacting_keyed_table #(
    parameter int CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // name_w0, name_w1, name_w2, name_w3, tag_w0, tag_w1, tag_w2, amount
    input  logic [ckt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic [ckt_pkg::MODE_W-1:0]    s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // position, out_name_w0..w3, out_tag_w0..w2, out_amount, zero padding
    output logic [ckt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [ckt_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int NAME_W   = ckt_pkg::NAME_W;
    localparam int TAG_W    = ckt_pkg::TAG_W;
    localparam int AMOUNT_W = ckt_pkg::AMOUNT_W;
    localparam int POS_W    = ckt_pkg::POS_W;
    localparam int ENTRY_W  = ckt_pkg::ENTRY_W;

    ckt_pkg::state_t state_reg, state_next;
    ckt_pkg::mode_t  mode_reg, mode_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [NAME_W-1:0]             key_reg, key_next;
    logic [ckt_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                          res_found_reg, res_found_next;

    logic                          m_valid_reg, m_valid_next;
    logic [ckt_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [POS_W-1:0]              m_pos_reg, m_pos_next;
    logic [NAME_W-1:0]             m_name_reg, m_name_next;
    logic [TAG_W-1:0]              m_tag_reg, m_tag_next;
    logic [AMOUNT_W-1:0]           m_amount_reg, m_amount_next;
    logic                          m_last_reg, m_last_next;

    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [ENTRY_W-1:0]            rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [ENTRY_W-1:0]            wr_data;

    logic                          s_accept;
    logic                          out_free;
    logic                          key_match;
    logic                          last_idx;
    logic                          table_full;
    logic                          table_empty;
    ckt_pkg::mode_t                s_mode;

    ckt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ckt_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_mode        = ckt_pkg::mode_t'(s_axis_tuser);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign key_match     = (rd_data[ckt_pkg::NAME_LO +: NAME_W] == key_reg);
    assign last_idx      = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full    = (count_reg == CNT_W'(CAPACITY));
    assign table_empty   = (count_reg == '0);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;

        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_pos_next    = m_pos_reg;
        m_name_next   = m_name_reg;
        m_tag_next    = m_tag_reg;
        m_amount_next = m_amount_reg;
        m_last_next   = m_last_reg;

        rd_en   = 1'b0;
        rd_addr = issue_idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = s_axis_tdata[ENTRY_W-1:0];

        case (state_reg)
            ckt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    mode_next      = s_mode;
                    key_next       = s_axis_tdata[ckt_pkg::NAME_LO +: NAME_W];
                    res_found_next = 1'b0;
                    // Every walk starts by reading the first entry.
                    rd_addr        = '0;
                    case (s_mode)
                        ckt_pkg::MODE_INSERT: begin
                            state_next = ckt_pkg::ST_RESP;
                            if (table_full) begin
                                res_status_next = ckt_pkg::STATUS_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ckt_pkg::STATUS_OK;
                            end
                        end
                        ckt_pkg::MODE_REMOVE, ckt_pkg::MODE_SEARCH: begin
                            if (table_empty) begin
                                state_next      = ckt_pkg::ST_RESP;
                                res_status_next = (s_mode == ckt_pkg::MODE_REMOVE)
                                                ? ckt_pkg::STATUS_EMPTY
                                                : ckt_pkg::STATUS_NOT_FOUND;
                            end else begin
                                state_next     = ckt_pkg::ST_SCAN;
                                rd_en          = 1'b1;
                                issue_idx_next = CNT_W'(1);
                                cmp_idx_next   = '0;
                                cmp_valid_next = 1'b1;
                            end
                        end
                        ckt_pkg::MODE_LIST: begin
                            if (table_empty) begin
                                state_next      = ckt_pkg::ST_RESP;
                                res_status_next = ckt_pkg::STATUS_LIST_EMPTY;
                            end else begin
                                state_next     = ckt_pkg::ST_LIST;
                                rd_en          = 1'b1;
                                issue_idx_next = CNT_W'(1);
                                cmp_idx_next   = '0;
                                cmp_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            state_next = ckt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            ckt_pkg::ST_SCAN: begin
                if (key_match) begin
                    // The read port stops here, so the hit stays on rd_data.
                    cmp_valid_next = 1'b0;
                    if (mode_reg == ckt_pkg::MODE_SEARCH) begin
                        res_found_next  = 1'b1;
                        res_status_next = ckt_pkg::STATUS_OK;
                        state_next      = ckt_pkg::ST_RESP;
                    end else if (last_idx) begin
                        count_next      = count_reg - CNT_W'(1);
                        res_status_next = ckt_pkg::STATUS_OK;
                        state_next      = ckt_pkg::ST_RESP;
                    end else begin
                        // issue_idx already points one past the hit.
                        state_next = ckt_pkg::ST_SHIFT;
                    end
                end else if (last_idx) begin
                    cmp_valid_next  = 1'b0;
                    res_status_next = ckt_pkg::STATUS_NOT_FOUND;
                    state_next      = ckt_pkg::ST_RESP;
                end else begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
            end

            ckt_pkg::ST_SHIFT: begin
                // Entry i arrives on rd_data and is written one place lower
                // while entry i + 1 is being read.
                if (cmp_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - IDX_W'(1);
                    wr_data = rd_data;
                end
                if (cmp_valid_reg && last_idx) begin
                    cmp_valid_next  = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = ckt_pkg::STATUS_OK;
                    state_next      = ckt_pkg::ST_RESP;
                end else begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
            end

            ckt_pkg::ST_LIST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ckt_pkg::STATUS_OK;
                    m_pos_next    = POS_W'(cmp_idx_reg);
                    m_name_next   = rd_data[ckt_pkg::NAME_LO +: NAME_W];
                    m_tag_next    = rd_data[ckt_pkg::TAG_LO +: TAG_W];
                    m_amount_next = rd_data[ckt_pkg::AMOUNT_LO +: AMOUNT_W];
                    m_last_next   = last_idx;
                    if (last_idx) begin
                        cmp_valid_next = 1'b0;
                        state_next     = ckt_pkg::ST_IDLE;
                    end else begin
                        rd_en          = 1'b1;
                        cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                        issue_idx_next = issue_idx_reg + CNT_W'(1);
                    end
                end
            end

            ckt_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_last_next   = 1'b1;
                    m_name_next   = '0;
                    if (res_found_reg) begin
                        m_pos_next    = POS_W'(cmp_idx_reg);
                        m_tag_next    = rd_data[ckt_pkg::TAG_LO +: TAG_W];
                        m_amount_next = rd_data[ckt_pkg::AMOUNT_LO +: AMOUNT_W];
                    end else begin
                        m_pos_next    = '0;
                        m_tag_next    = '0;
                        m_amount_next = '0;
                    end
                    state_next = ckt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next     = ckt_pkg::ST_IDLE;
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ckt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
        m_name_reg     <= m_name_next;
        m_tag_reg      <= m_tag_next;
        m_amount_reg   <= m_amount_next;
        m_last_reg     <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = ckt_pkg::M_TDATA_W'({m_amount_reg, m_tag_reg, m_name_reg,
                                                m_pos_reg});

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the compacting keyed table
// Drives insert, remove, search and list requests on the input stream and
// checks every result beat against a table model kept in the bench. A short
// directed table covers the empty, full, duplicate and padding corner cases;
// random traffic then fills and drains the table under four idling patterns.
// ============================================================================
module tb;

    localparam int          CAPACITY    = 16;
    localparam int          POOL_SIZE   = 6;
    localparam int          RAND_PHASES = 4;
    localparam int          PHASE_ITEMS = 60;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 64;
    localparam int unsigned LIMIT       = 400000;

    localparam int NAME_W   = ckt_pkg::NAME_W;
    localparam int TAG_W    = ckt_pkg::TAG_W;
    localparam int AMOUNT_W = ckt_pkg::AMOUNT_W;
    localparam int POS_W    = ckt_pkg::POS_W;
    localparam int STATUS_W = ckt_pkg::STATUS_W;

    localparam logic [NAME_W-1:0] NAME_ONES = '1;
    localparam logic [NAME_W-1:0] NAME_ZERO = '0;
    // "abc" followed by a stray byte beyond the terminator
    localparam logic [NAME_W-1:0] JUNK_ABC  = 256'h0000_7800_0063_6261;
    localparam logic [NAME_W-1:0] CLEAN_ABC = 256'h0000_0000_0063_6261;
    localparam logic [NAME_W-1:0] FILL_NAME = 256'h6c6c_6966;
    localparam logic [TAG_W-1:0]  TAG_ONES  = '1;
    localparam logic [TAG_W-1:0]  TAG_ZERO  = '0;
    localparam logic [TAG_W-1:0]  TAG_PLAIN = 192'h6e6f_6d6d_6f63;

    typedef struct {
        ckt_pkg::mode_t        mode;
        logic [NAME_W-1:0]     name;
        logic [TAG_W-1:0]      tag;
        logic [AMOUNT_W-1:0]   amount;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [POS_W-1:0]      position;
        logic [NAME_W-1:0]     name;
        logic [TAG_W-1:0]      tag;
        logic [AMOUNT_W-1:0]   amount;
        logic                  last;
    } result_t;

    // One row of the directed walk; a typed row carries its own status and
    // expects all data fields zero with last set.
    typedef struct {
        int                    reps;
        ckt_pkg::mode_t        mode;
        logic [NAME_W-1:0]     name;
        logic [TAG_W-1:0]      tag;
        logic [AMOUNT_W-1:0]   amount;
        bit                    typed;
        logic [STATUS_W-1:0]   status;
        bit                    stall_rx;
    } row_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ckt_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [ckt_pkg::MODE_W-1:0]    s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ckt_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]           m_axis_tuser;
    logic                          m_axis_tlast;

    // Bench copy of the table contents
    logic [NAME_W-1:0]     tbl_name   [CAPACITY];
    logic [TAG_W-1:0]      tbl_tag    [CAPACITY];
    logic [AMOUNT_W-1:0]   tbl_amount [CAPACITY];
    int                    tbl_count;

    result_t               step_results [$];
    result_t               awaited      [$];
    logic [NAME_W-1:0]     name_pool    [POOL_SIZE];
    row_t                  dir_rows     [$];

    int                    idle_pct      = 0;
    int                    stall_pct     = 0;
    int                    hold_requests = 0;
    int                    holds_served  = 0;
    int                    hold_left     = 0;
    int                    mismatches    = 0;
    int                    beats_checked = 0;
    int                    requests_sent = 0;
    int                    peak_count    = 0;
    int                    full_rejects  = 0;
    int                    empty_hits    = 0;
    int                    name_misses   = 0;
    int unsigned           cycle_count   = 0;

    compacting_keyed_table #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_axis_tready <= 1'b0;
            holds_served  <= hold_requests;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string field, input logic [NAME_W-1:0] want,
                               input logic [NAME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status   = m_axis_tuser;
            got.position = m_axis_tdata[POS_W-1:0];
            got.name     = m_axis_tdata[POS_W+ckt_pkg::NAME_LO +: NAME_W];
            got.tag      = m_axis_tdata[POS_W+ckt_pkg::TAG_LO +: TAG_W];
            got.amount   = m_axis_tdata[POS_W+ckt_pkg::AMOUNT_LO +: AMOUNT_W];
            got.last     = m_axis_tlast;
            if (awaited.size() == 0) begin
                $error("result beat with nothing expected: status %0d", got.status);
                mismatches++;
            end else begin
                want = awaited.pop_front();
                beats_checked++;
                check_field("status", NAME_W'(want.status), NAME_W'(got.status));
                check_field("position", NAME_W'(want.position), NAME_W'(got.position));
                check_field("out_name", want.name, got.name);
                check_field("out_tag", NAME_W'(want.tag), NAME_W'(got.tag));
                check_field("out_amount", NAME_W'(want.amount), NAME_W'(got.amount));
                check_field("last", NAME_W'(want.last), NAME_W'(got.last));
            end
        end
    end

    // Applies one accepted request to the bench table and leaves the result
    // beats it should produce in step_results.
    function automatic void apply_request(input request_t rq);
        int      hit;
        int      i;
        result_t res;
        step_results.delete();
        hit = -1;
        for (i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_name[i] == rq.name)
                hit = i;
        res = '{default: '0};
        res.last = 1'b1;
        case (rq.mode)
            ckt_pkg::MODE_INSERT: begin
                if (tbl_count >= CAPACITY) begin
                    res.status = ckt_pkg::STATUS_FULL;
                    full_rejects++;
                end else begin
                    tbl_name[tbl_count]   = rq.name;
                    tbl_tag[tbl_count]    = rq.tag;
                    tbl_amount[tbl_count] = rq.amount;
                    tbl_count++;
                    if (tbl_count > peak_count)
                        peak_count = tbl_count;
                end
                step_results.push_back(res);
            end
            ckt_pkg::MODE_REMOVE: begin
                if (tbl_count == 0) begin
                    res.status = ckt_pkg::STATUS_EMPTY;
                    empty_hits++;
                end else if (hit < 0) begin
                    res.status = ckt_pkg::STATUS_NOT_FOUND;
                    name_misses++;
                end else begin
                    // Later entries close the gap left by the removed one.
                    for (i = hit; i + 1 < tbl_count; i++) begin
                        tbl_name[i]   = tbl_name[i+1];
                        tbl_tag[i]    = tbl_tag[i+1];
                        tbl_amount[i] = tbl_amount[i+1];
                    end
                    tbl_count--;
                end
                step_results.push_back(res);
            end
            ckt_pkg::MODE_SEARCH: begin
                if (hit < 0) begin
                    res.status = ckt_pkg::STATUS_NOT_FOUND;
                    name_misses++;
                end else begin
                    res.position = hit[POS_W-1:0];
                    res.tag      = tbl_tag[hit];
                    res.amount   = tbl_amount[hit];
                end
                step_results.push_back(res);
            end
            default: begin
                if (tbl_count == 0) begin
                    res.status = ckt_pkg::STATUS_LIST_EMPTY;
                    empty_hits++;
                    step_results.push_back(res);
                end
                for (i = 0; i < tbl_count; i++) begin
                    res.position = i[POS_W-1:0];
                    res.name     = tbl_name[i];
                    res.tag      = tbl_tag[i];
                    res.amount   = tbl_amount[i];
                    res.last     = (i == tbl_count - 1);
                    step_results.push_back(res);
                end
            end
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] random_wide();
        logic [NAME_W-1:0] v;
        int                w;
        for (w = 0; w < NAME_W / 32; w++)
            v[32*w +: 32] = $urandom;
        return v;
    endfunction

    // Fill phases lean on inserts, drain phases on removes. Removes and
    // searches mostly name an entry that is really there.
    function automatic request_t random_request(input bit filling);
        request_t          rq;
        logic [NAME_W-1:0] wide;
        int                roll;
        int                pick;
        roll = $urandom_range(99);
        if (filling)
            rq.mode = roll < 55 ? ckt_pkg::MODE_INSERT :
                      roll < 70 ? ckt_pkg::MODE_REMOVE :
                      roll < 90 ? ckt_pkg::MODE_SEARCH : ckt_pkg::MODE_LIST;
        else
            rq.mode = roll < 15 ? ckt_pkg::MODE_INSERT :
                      roll < 70 ? ckt_pkg::MODE_REMOVE :
                      roll < 90 ? ckt_pkg::MODE_SEARCH : ckt_pkg::MODE_LIST;
        wide      = random_wide();
        rq.tag    = wide[TAG_W-1:0];
        rq.amount = $urandom;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (rq.mode != ckt_pkg::MODE_INSERT && tbl_count > 0 && roll < 70) begin
            rq.name = tbl_name[$urandom_range(tbl_count - 1)];
        end else if (pick < 60) begin
            rq.name = name_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 80) begin
            // A near miss: one word of a known name replaced
            rq.name = name_pool[$urandom_range(POOL_SIZE - 1)];
            rq.name[64*$urandom_range(3) +: 64] = {$urandom, $urandom};
        end else begin
            rq.name = random_wide();
        end
        return rq;
    endfunction

    task automatic drive_request(input request_t rq);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.amount, rq.tag, rq.name};
        s_axis_tuser  <= rq.mode;
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited.size() != 0);
    endtask

    function automatic row_t mk_row(input int reps, input ckt_pkg::mode_t mode,
                                    input logic [NAME_W-1:0] name,
                                    input logic [TAG_W-1:0] tag,
                                    input logic [AMOUNT_W-1:0] amount, input bit typed,
                                    input logic [STATUS_W-1:0] status, input bit stall_rx);
        row_t r;
        r = '{reps, mode, name, tag, amount, typed, status, stall_rx};
        return r;
    endfunction

    initial begin
        request_t rq;
        result_t  fixed;
        int       r;
        int       k;
        int       p;

        //                    reps mode                  name       tag       amount
        //                         typed status                       hold
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_LIST,   NAME_ONES, TAG_ONES, 32'h0,
                                  1, ckt_pkg::STATUS_LIST_EMPTY, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_REMOVE, NAME_ONES, TAG_ZERO, 32'h0,
                                  1, ckt_pkg::STATUS_EMPTY, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_SEARCH, NAME_ONES, TAG_ZERO, 32'h0,
                                  1, ckt_pkg::STATUS_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_INSERT, NAME_ONES, TAG_ONES,
                                  32'h7fff_ffff, 1, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_INSERT, NAME_ZERO, TAG_ZERO,
                                  32'h8000_0000, 1, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_INSERT, JUNK_ABC, TAG_PLAIN,
                                  32'hffff_ffff, 1, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_INSERT, NAME_ONES, TAG_PLAIN, 32'h1,
                                  1, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_SEARCH, NAME_ONES, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_SEARCH, CLEAN_ABC, TAG_ZERO, 32'h0,
                                  1, ckt_pkg::STATUS_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_SEARCH, JUNK_ABC, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_LIST,   NAME_ZERO, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_REMOVE, NAME_ONES, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_SEARCH, NAME_ONES, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_REMOVE, CLEAN_ABC, TAG_ZERO, 32'h0,
                                  1, ckt_pkg::STATUS_NOT_FOUND, 0));
        dir_rows.push_back(mk_row(13, ckt_pkg::MODE_INSERT, FILL_NAME, TAG_PLAIN,
                                  32'h5a5a_a5a5, 1, ckt_pkg::STATUS_OK, 1));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_INSERT, NAME_ONES, TAG_ONES,
                                  32'h7fff_ffff, 1, ckt_pkg::STATUS_FULL, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_LIST,   NAME_ZERO, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_REMOVE, NAME_ZERO, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_REMOVE, FILL_NAME ^ NAME_W'(12),
                                  TAG_ZERO, 32'h0, 0, ckt_pkg::STATUS_OK, 0));
        dir_rows.push_back(mk_row(1, ckt_pkg::MODE_LIST,   NAME_ZERO, TAG_ZERO, 32'h0,
                                  0, ckt_pkg::STATUS_OK, 0));

        tbl_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (p = 0; p < POOL_SIZE; p++)
            name_pool[p] = random_wide();

        // Directed walk; the fill row starts a long result hold-off so the
        // block backs up and stalls its input.
        for (r = 0; r < dir_rows.size(); r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                rq.mode   = dir_rows[r].mode;
                rq.name   = dir_rows[r].name ^ NAME_W'(k);
                rq.tag    = dir_rows[r].tag;
                rq.amount = dir_rows[r].amount;
                if (dir_rows[r].stall_rx && k == 0)
                    hold_requests++;
                drive_request(rq);
                apply_request(rq);
                if (dir_rows[r].typed) begin
                    fixed        = '{default: '0};
                    fixed.status = dir_rows[r].status;
                    fixed.last   = 1'b1;
                    awaited.push_back(fixed);
                end else begin
                    foreach (step_results[n])
                        awaited.push_back(step_results[n]);
                end
            end
        end
        wait_drained();

        // Random traffic: no idling, sender idle, receiver stalling, both.
        for (p = 0; p < RAND_PHASES; p++) begin
            idle_pct  = (p == 1) ? 86 : (p == 3) ? 33 : 0;
            stall_pct = (p == 2) ? 86 : (p == 3) ? 33 : 0;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                rq = random_request(((k / 24) % 2) == 0);
                drive_request(rq);
                apply_request(rq);
                foreach (step_results[n])
                    awaited.push_back(step_results[n]);
            end
            wait_drained();
        end

        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d requests and %0d result beats; the table peaked at %0d of %0d.",
                 requests_sent, beats_checked, peak_count, CAPACITY);
        $display("Seen %0d inserts refused as full, %0d empty-table requests, %0d name misses.",
                 full_rejects, empty_hits, name_misses);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
